// File: hdl/tpp_pkg.sv
// Shared types, codes and constants for the tape pulse player.
package tpp_pkg;

    localparam int TAPE_DEPTH_DEF   = 65536;
    localparam int HEADER_BYTES_DEF = 20;

    localparam int MODE_W      = 3;
    localparam int STEP_W      = 3;
    localparam int AUTOSTOP_W  = 24;
    localparam int IDLE_W      = 24;
    localparam int PLEN_W      = 24;
    localparam int PCNT_W      = 25;
    localparam int UNIT_SHIFT  = 3;   // short record: byte * 8 ticks

    localparam logic [AUTOSTOP_W-1:0] AUTOSTOP_RST = 24'd1000000;

    localparam logic [STEP_W-1:0] STEP_NONE  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SHORT = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LONG  = 3'd4;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PLAY   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REWIND = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOAD   = 3'd4;

    typedef struct packed {
        logic              read_pulse;
        logic [STEP_W-1:0] advance;
        logic              sense_line;
        logic              is_playing;
        logic              auto_stopped;
    } res_t;

endpackage

// File: hdl/tape_pulse_player_top.sv
// Tape pulse player top level: store, playback control and result buffer.
// Each result is registered, via the skid entry while the output stalls.
// Throughput: one transaction per cycle while s_ready is high; the store is read each
//   cycle at the position the next tick will use, so a record is ready with no stall.
// Reset (aresetn low, synchronous): stopped, length 0, position at the header
//   end, counters 0, autostop limit 1000000; store contents are undefined until loaded.
module tape_pulse_player_top
    import tpp_pkg::*;
#(
    parameter int TAPE_DEPTH   = TAPE_DEPTH_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // autostop limit register
    input  logic                  cfg_wr_en,
    input  logic [AUTOSTOP_W-1:0] cfg_wr_data,
    // command transactions
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MODE_W-1:0]     s_mode,
    input  logic                  s_motor_on,
    input  logic [7:0]            s_tape_byte,
    input  logic                  s_load_first,
    // result transactions
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_read_pulse,
    output logic [STEP_W-1:0]     m_advance,
    output logic                  m_sense_line,
    output logic                  m_is_playing,
    output logic                  m_auto_stopped
);

    localparam int POS_W = $clog2(TAPE_DEPTH + 260);

    logic             item_acc;
    logic [POS_W-1:0] rd_pos, wr_pos;
    logic             wr_en;
    logic [7:0]       wr_byte;
    logic [3:0][7:0]  rec_bytes;
    res_t             res, out_res;

    // a command is processed in its accept cycle; the result is registered
    assign item_acc = s_valid && s_ready;

    tpp_ctrl #(
        .TAPE_DEPTH   (TAPE_DEPTH),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_acc    (item_acc),
        .mode        (s_mode),
        .motor_on    (s_motor_on),
        .tape_byte   (s_tape_byte),
        .load_first  (s_load_first),
        .rec_bytes   (rec_bytes),
        .rd_pos      (rd_pos),
        .wr_en       (wr_en),
        .wr_pos      (wr_pos),
        .wr_byte     (wr_byte),
        .res         (res)
    );

    // four record bytes from the current position, with write forwarding
    tpp_store #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_pos    (wr_pos),
        .wr_byte   (wr_byte),
        .rd_pos    (rd_pos),
        .rec_bytes (rec_bytes)
    );

    // output register plus skid entry keeps s_ready off the m_ready path
    tpp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_acc),
        .in_res    (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_res   (out_res),
        .out_ready (m_ready)
    );

    assign m_read_pulse   = out_res.read_pulse;
    assign m_advance      = out_res.advance;
    assign m_sense_line   = out_res.sense_line;
    assign m_is_playing   = out_res.is_playing;
    assign m_auto_stopped = out_res.auto_stopped;

endmodule

// File: hdl/tpp_store.sv
// Tape byte store: word memory, byte writes, two read ports, write forwarding.
module tpp_store
    import tpp_pkg::*;
#(
    parameter int TAPE_DEPTH = TAPE_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  wr_en,
    input  logic [$clog2(TAPE_DEPTH+260)-1:0]     wr_pos,
    input  logic [7:0]                            wr_byte,
    input  logic [$clog2(TAPE_DEPTH+260)-1:0]     rd_pos,
    output logic [3:0][7:0]                       rec_bytes
);

    localparam int WORDS   = (TAPE_DEPTH + 3) / 4;
    localparam int WADDR_W = $clog2(WORDS);

    logic [3:0][7:0] mem [WORDS];

    logic [WADDR_W-1:0] wa, ra_a, ra_b;
    logic [1:0]         wl;
    logic [3:0][7:0]    rd_a_reg, rd_b_reg;
    logic [1:0]         lane_reg;
    logic               fwd_a_reg, fwd_b_reg;
    logic [1:0]         fwd_lane_reg;
    logic [7:0]         fwd_byte_reg;
    logic [3:0][7:0]    word_a, word_b;
    logic [7:0][7:0]    pair;

    assign wa   = WADDR_W'(wr_pos >> 2);
    assign wl   = wr_pos[1:0];
    assign ra_a = WADDR_W'(rd_pos >> 2);
    assign ra_b = ra_a + WADDR_W'(1);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wa][wl] <= wr_byte;
        end
        rd_a_reg     <= mem[ra_a];
        rd_b_reg     <= mem[ra_b];
        lane_reg     <= rd_pos[1:0];
        fwd_lane_reg <= wl;
        fwd_byte_reg <= wr_byte;
    end

    // read returns old data on a same-cycle write; patch the registered read data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_a_reg <= 1'b0;
            fwd_b_reg <= 1'b0;
        end else begin
            fwd_a_reg <= wr_en && (wa == ra_a);
            fwd_b_reg <= wr_en && (wa == ra_b);
        end
    end

    always_comb begin
        word_a = rd_a_reg;
        word_b = rd_b_reg;
        if (fwd_a_reg) begin
            word_a[fwd_lane_reg] = fwd_byte_reg;
        end
        if (fwd_b_reg) begin
            word_b[fwd_lane_reg] = fwd_byte_reg;
        end
        pair = {word_b, word_a};
        for (int k = 0; k < 4; k++) begin
            rec_bytes[k] = pair[{1'b0, lane_reg} + 3'(k)];
        end
    end

endmodule

// File: hdl/tpp_ctrl.sv
// Playback control: position, length, counters, command decode, result build.
module tpp_ctrl
    import tpp_pkg::*;
#(
    parameter int TAPE_DEPTH   = TAPE_DEPTH_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [AUTOSTOP_W-1:0]                 cfg_wr_data,
    input  logic                                  item_acc,
    input  logic [MODE_W-1:0]                     mode,
    input  logic                                  motor_on,
    input  logic [7:0]                            tape_byte,
    input  logic                                  load_first,
    input  logic [3:0][7:0]                       rec_bytes,
    output logic [$clog2(TAPE_DEPTH+260)-1:0]     rd_pos,
    output logic                                  wr_en,
    output logic [$clog2(TAPE_DEPTH+260)-1:0]     wr_pos,
    output logic [7:0]                            wr_byte,
    output res_t                                  res
);

    localparam int LEN_W = $clog2(TAPE_DEPTH + 1);
    localparam int POS_W = $clog2(TAPE_DEPTH + 260);

    logic [LEN_W-1:0]      len_reg, len_next, len_base;
    logic [POS_W-1:0]      pos_reg, pos_next, len_ext;
    logic [PCNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDLE_W-1:0]     idle_reg, idle_next, idle_inc;
    logic                  play_reg, play_next;
    logic [AUTOSTOP_W-1:0] autostop_reg;

    logic [3:0]            byte_ok;
    logic [3:0][7:0]       rec;
    logic                  is_long, pulse_hit;
    logic [PLEN_W-1:0]     plen;

    // record bytes at or past the loaded length read as zero
    always_comb begin
        len_ext = POS_W'(len_reg);
        for (int k = 0; k < 4; k++) begin
            byte_ok[k] = (pos_reg + POS_W'(k)) < len_ext;
            rec[k]     = byte_ok[k] ? rec_bytes[k] : 8'd0;
        end
        is_long   = (rec[0] == 8'd0);
        plen      = is_long ? {rec[3], rec[2], rec[1]}
                            : {13'd0, rec[0], 3'd0};
        pulse_hit = cnt_reg >= {1'b0, plen};
        idle_inc  = (idle_reg != '1) ? idle_reg + IDLE_W'(1) : idle_reg;
    end

    always_comb begin
        len_next  = len_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        idle_next = idle_reg;
        play_next = play_reg;
        len_base  = load_first ? '0 : len_reg;
        wr_en     = 1'b0;
        wr_pos    = POS_W'(len_base);
        wr_byte   = tape_byte;
        res       = '0;
        if (item_acc) begin
            case (mode)
                MODE_TICK: begin
                    if (play_reg && motor_on && byte_ok[0]) begin
                        if (pulse_hit) begin
                            res.read_pulse = 1'b1;
                            res.advance    = is_long ? STEP_LONG : STEP_SHORT;
                            pos_next       = pos_reg + POS_W'(res.advance);
                            cnt_next       = PCNT_W'(1);
                        end else if (cnt_reg != '1) begin
                            cnt_next = cnt_reg + PCNT_W'(1);
                        end
                    end else if (play_reg) begin
                        if (idle_inc >= autostop_reg) begin
                            idle_next        = '0;
                            play_next        = 1'b0;
                            res.auto_stopped = 1'b1;
                        end else begin
                            idle_next = idle_inc;
                        end
                    end
                end
                MODE_PLAY:   play_next = 1'b1;
                MODE_STOP:   play_next = 1'b0;
                MODE_REWIND: pos_next  = POS_W'(HEADER_BYTES);
                MODE_LOAD: begin
                    if (load_first) begin
                        pos_next = POS_W'(HEADER_BYTES);
                    end
                    len_next = len_base;
                    if (len_base < LEN_W'(TAPE_DEPTH)) begin
                        wr_en    = 1'b1;
                        len_next = len_base + LEN_W'(1);
                    end
                end
                default: ;
            endcase
        end
        res.sense_line = !play_next;
        res.is_playing = play_next;
    end

    // the store is always read at the position the next item will see
    assign rd_pos = pos_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg      <= '0;
            pos_reg      <= POS_W'(HEADER_BYTES);
            cnt_reg      <= '0;
            idle_reg     <= '0;
            play_reg     <= 1'b0;
            autostop_reg <= AUTOSTOP_RST;
        end else begin
            len_reg  <= len_next;
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            idle_reg <= idle_next;
            play_reg <= play_next;
            if (cfg_wr_en) begin
                autostop_reg <= cfg_wr_data;
            end
        end
    end

endmodule

// File: hdl/tpp_skid.sv
// Result output register with a skid stage.
module tpp_skid
    import tpp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  res_t in_res,
    output logic in_ready,
    output logic out_valid,
    output res_t out_res,
    input  logic out_ready
);

    logic out_vld_reg, skid_vld_reg;
    res_t out_reg, skid_reg;

    assign in_ready  = !skid_vld_reg;
    assign out_valid = out_vld_reg;
    assign out_res   = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_ready || !out_vld_reg) begin
            if (skid_vld_reg) begin
                out_reg      <= skid_reg;
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_reg     <= in_res;
                out_vld_reg <= in_valid;
            end
        end else if (in_valid) begin
            skid_reg     <= in_res;
            skid_vld_reg <= 1'b1;
        end
    end

endmodule

// File: hdl/tpp_checker.sv
// Port-level checker for the tape pulse player and its bind.
module tpp_checker
    import tpp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic              m_read_pulse,
    input logic [STEP_W-1:0] m_advance,
    input logic              m_sense_line,
    input logic              m_is_playing,
    input logic              m_auto_stopped
);

    // stalled result holds its advance and read pulse
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_advance) && $stable(m_read_pulse))
        else $error("stalled result changed");

    a_sense: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sense_line != m_is_playing)
        else $error("sense line disagrees with playing flag");

    a_pulse_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_read_pulse && (m_advance == STEP_SHORT || m_advance == STEP_LONG))
                 || (!m_read_pulse && m_advance == STEP_NONE))
        else $error("advance does not match read pulse");

    a_autostop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_auto_stopped |-> !m_is_playing && !m_read_pulse)
        else $error("autostop with playback still running");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind tape_pulse_player_top tpp_checker u_tpp_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_pulse   (m_read_pulse),
    .m_advance      (m_advance),
    .m_sense_line   (m_sense_line),
    .m_is_playing   (m_is_playing),
    .m_auto_stopped (m_auto_stopped)
);
